FILE: sv/dlm_pkg.sv
// Shared types, constants and helpers of the deadband linear map.
package dlm_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int CFG_IDX_W = 3;
	localparam int REGION_W = 3;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic signed [VALUE_WIDTH:0] dif_t;
	typedef logic [VALUE_WIDTH-1:0] mag_t;
	typedef logic [2*VALUE_WIDTH-1:0] prod_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [REGION_W-1:0] region_t;

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_INV = 1'b1;

	localparam region_t REGION_CLAMP_LOW = 3'd0;
	localparam region_t REGION_LOWER = 3'd1;
	localparam region_t REGION_MID = 3'd2;
	localparam region_t REGION_UPPER = 3'd3;
	localparam region_t REGION_CLAMP_HIGH = 3'd4;

	localparam cfg_idx_t REG_SRC_LOWEST = 3'd0;
	localparam cfg_idx_t REG_SRC_BAND_LOW = 3'd1;
	localparam cfg_idx_t REG_SRC_CENTER = 3'd2;
	localparam cfg_idx_t REG_SRC_BAND_HIGH = 3'd3;
	localparam cfg_idx_t REG_SRC_HIGHEST = 3'd4;
	localparam cfg_idx_t REG_DST_LOWEST = 3'd5;
	localparam cfg_idx_t REG_DST_CENTER = 3'd6;
	localparam cfg_idx_t REG_DST_HIGHEST = 3'd7;

	localparam val_t RST_SRC_LOWEST = val_t'(-32768);
	localparam val_t RST_SRC_BAND_LOW = val_t'(-1024);
	localparam val_t RST_SRC_CENTER = val_t'(0);
	localparam val_t RST_SRC_BAND_HIGH = val_t'(1024);
	localparam val_t RST_SRC_HIGHEST = val_t'(32767);
	localparam val_t RST_DST_LOWEST = val_t'(-32768);
	localparam val_t RST_DST_CENTER = val_t'(0);
	localparam val_t RST_DST_HIGHEST = val_t'(32767);

	typedef struct packed {
		val_t src_lowest;
		val_t src_band_low;
		val_t src_center;
		val_t src_band_high;
		val_t src_highest;
		val_t dst_lowest;
		val_t dst_center;
		val_t dst_highest;
	} cfg_t;

	// Partial division state carried from cell to cell.
	typedef struct packed {
		mag_t rem;
		mag_t dvd;
		mag_t quo;
		mag_t dsr;
	} div_t;

	// Side information that travels with each request down the chain.
	typedef struct packed {
		logic seg;
		logic neg;
		val_t base;
		region_t region;
	} tag_t;

	typedef struct packed {
		val_t mapped;
		region_t region;
	} res_t;

	function automatic dif_t sub_ext(val_t p, val_t q);
		return dif_t'({p[VALUE_WIDTH-1], p}) - dif_t'({q[VALUE_WIDTH-1], q});
	endfunction

endpackage

FILE: sv/dlm_if.sv
// Request and result channel interfaces of the deadband linear map.
interface dlm_in_if;
	import dlm_pkg::*;
	logic valid;
	logic ready;
	logic command;
	val_t sample;
	modport source(output valid, command, sample, input ready);
	modport sink(input valid, command, sample, output ready);
endinterface

interface dlm_out_if;
	import dlm_pkg::*;
	logic valid;
	logic ready;
	val_t mapped;
	region_t region;
	modport source(output valid, mapped, region, input ready);
	modport sink(input valid, mapped, region, output ready);
endinterface

FILE: sv/deadband_linear_map.sv
// Top level of the deadband linear map: configuration, divider cell chain and output stage.
//
//   channel    dir   payload                 handshake
//   samples    in    command, sample         valid / ready
//   results    out   mapped, region          valid / ready
//   cfg        in    cfg_idx, cfg_data       cfg_we, no wait
//
// One request is taken per cycle while ready is high; each result passes the decode register,
// the product register, one cell per quotient bit and the output register.
// Reset clears all valid flags and loads the configuration registers with their default values.
// A stalled result is held in the output register and one more in a skid register;
// ready drops only while the skid register is full, and the whole chain then holds.
module deadband_linear_map (
	input logic clk,
	input logic arst_n,
	dlm_in_if.sink samples,
	dlm_out_if.source results,
	input logic cfg_we,
	input dlm_pkg::cfg_idx_t cfg_idx,
	input dlm_pkg::val_t cfg_data
);
	import dlm_pkg::*;

	cfg_t cfg_q;
	logic adv;
	logic [VALUE_WIDTH:0] chain_vld;
	div_t chain_div [VALUE_WIDTH+1];
	tag_t chain_tag [VALUE_WIDTH+1];

	logic out_vld_q;
	logic skid_vld_q;
	res_t out_q;
	res_t skid_q;
	res_t tail;
	logic out_take;

	logic signed [VALUE_WIDTH:0] q_signed;
	logic signed [VALUE_WIDTH+1:0] sum;
	logic [VALUE_WIDTH-1:0] quo;
	tag_t tail_tag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_lowest <= RST_SRC_LOWEST;
			cfg_q.src_band_low <= RST_SRC_BAND_LOW;
			cfg_q.src_center <= RST_SRC_CENTER;
			cfg_q.src_band_high <= RST_SRC_BAND_HIGH;
			cfg_q.src_highest <= RST_SRC_HIGHEST;
			cfg_q.dst_lowest <= RST_DST_LOWEST;
			cfg_q.dst_center <= RST_DST_CENTER;
			cfg_q.dst_highest <= RST_DST_HIGHEST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SRC_LOWEST: cfg_q.src_lowest <= cfg_data;
				REG_SRC_BAND_LOW: cfg_q.src_band_low <= cfg_data;
				REG_SRC_CENTER: cfg_q.src_center <= cfg_data;
				REG_SRC_BAND_HIGH: cfg_q.src_band_high <= cfg_data;
				REG_SRC_HIGHEST: cfg_q.src_highest <= cfg_data;
				REG_DST_LOWEST: cfg_q.dst_lowest <= cfg_data;
				REG_DST_CENTER: cfg_q.dst_center <= cfg_data;
				REG_DST_HIGHEST: cfg_q.dst_highest <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !skid_vld_q;
	assign samples.ready = adv;

	dlm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.vld_i(samples.valid),
		.command(samples.command),
		.sample(samples.sample),
		.cfg(cfg_q),
		.vld_q(chain_vld[0]),
		.div_q(chain_div[0]),
		.tag_q(chain_tag[0])
	);

	for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
		dlm_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.vld_i(chain_vld[i]),
			.div_i(chain_div[i]),
			.tag_i(chain_tag[i]),
			.vld_q(chain_vld[i+1]),
			.div_q(chain_div[i+1]),
			.tag_q(chain_tag[i+1])
		);
	end

	always_comb begin
		tail_tag = chain_tag[VALUE_WIDTH];
		quo = chain_div[VALUE_WIDTH].quo;
		q_signed = tail_tag.neg ? -{1'b0, quo} : {1'b0, quo};
		sum = {q_signed[VALUE_WIDTH], q_signed}
			+ {{2{tail_tag.base[VALUE_WIDTH-1]}}, tail_tag.base};
		tail.region = tail_tag.region;
		if (!tail_tag.seg) begin
			tail.mapped = tail_tag.base;
		end else if (sum[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b000
				|| sum[VALUE_WIDTH+1:VALUE_WIDTH-1] == 3'b111) begin
			tail.mapped = sum[VALUE_WIDTH-1:0];
		end else begin
			tail.mapped = sum[VALUE_WIDTH+1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
				: {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end
	end

	assign out_take = out_vld_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (chain_vld[VALUE_WIDTH]) begin
			if (out_vld_q && !results.ready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (chain_vld[VALUE_WIDTH]) begin
			if (out_vld_q && !results.ready) begin
				skid_q <= tail;
			end else begin
				out_q <= tail;
			end
		end
	end

	assign results.valid = out_vld_q;
	assign results.mapped = out_q.mapped;
	assign results.region = out_q.region;

endmodule

FILE: sv/dlm_front.sv
// Region decode, operand selection and product stage ahead of the divider chain.
module dlm_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input logic command,
	input dlm_pkg::val_t sample,
	input dlm_pkg::cfg_t cfg,
	output logic vld_q,
	output dlm_pkg::div_t div_q,
	output dlm_pkg::tag_t tag_q
);
	import dlm_pkg::*;

	dif_t a_dif;
	dif_t b_dif;
	dif_t c_dif;
	dif_t b_neg_dif;
	tag_t tag_d;
	logic seg_d;

	logic vld_s1;
	mag_t a_s1;
	mag_t b_s1;
	mag_t c_s1;
	tag_t tag_s1;
	prod_t prod;

	always_comb begin
		a_dif = '0;
		b_dif = '0;
		c_dif = '0;
		seg_d = 1'b0;
		tag_d.base = cfg.dst_center;
		tag_d.region = REGION_MID;
		if (command == CMD_FWD) begin
			if (sample <= cfg.src_lowest) begin
				tag_d.base = cfg.dst_lowest;
				tag_d.region = REGION_CLAMP_LOW;
			end else if (sample >= cfg.src_highest) begin
				tag_d.base = cfg.dst_highest;
				tag_d.region = REGION_CLAMP_HIGH;
			end else if (sample < cfg.src_band_low) begin
				seg_d = 1'b1;
				a_dif = sub_ext(sample, cfg.src_lowest);
				b_dif = sub_ext(cfg.dst_center, cfg.dst_lowest);
				c_dif = sub_ext(cfg.src_band_low, cfg.src_lowest);
				tag_d.base = cfg.dst_lowest;
				tag_d.region = REGION_LOWER;
			end else if (sample > cfg.src_band_high) begin
				seg_d = 1'b1;
				a_dif = sub_ext(sample, cfg.src_band_high);
				b_dif = sub_ext(cfg.dst_highest, cfg.dst_center);
				c_dif = sub_ext(cfg.src_highest, cfg.src_band_high);
				tag_d.base = cfg.dst_center;
				tag_d.region = REGION_UPPER;
			end
		end else begin
			if (sample <= cfg.dst_lowest) begin
				tag_d.base = cfg.src_lowest;
				tag_d.region = REGION_CLAMP_LOW;
			end else if (sample >= cfg.dst_highest) begin
				tag_d.base = cfg.src_highest;
				tag_d.region = REGION_CLAMP_HIGH;
			end else if (sample == cfg.dst_center) begin
				tag_d.base = cfg.src_center;
				tag_d.region = REGION_MID;
			end else if (sample < cfg.dst_center) begin
				seg_d = 1'b1;
				a_dif = sub_ext(sample, cfg.dst_lowest);
				b_dif = sub_ext(cfg.src_band_low, cfg.src_lowest);
				c_dif = sub_ext(cfg.dst_center, cfg.dst_lowest);
				tag_d.base = cfg.src_lowest;
				tag_d.region = REGION_LOWER;
			end else begin
				seg_d = 1'b1;
				a_dif = sub_ext(sample, cfg.dst_center);
				b_dif = sub_ext(cfg.src_highest, cfg.src_band_high);
				c_dif = sub_ext(cfg.dst_highest, cfg.dst_center);
				tag_d.base = cfg.src_band_high;
				tag_d.region = REGION_UPPER;
			end
		end
		// In a segment the offset is positive and smaller than the span, so the
		// quotient stays below the slope magnitude; a zero span clears seg, so the base is passed on.
		b_neg_dif = -b_dif;
		tag_d.neg = b_dif[VALUE_WIDTH];
		tag_d.seg = seg_d && (c_dif != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_dif[VALUE_WIDTH-1:0];
			b_s1 <= tag_d.neg ? b_neg_dif[VALUE_WIDTH-1:0] : b_dif[VALUE_WIDTH-1:0];
			c_s1 <= c_dif[VALUE_WIDTH-1:0];
			tag_s1 <= tag_d;
		end
	end

	assign prod = prod_t'(a_s1) * prod_t'(b_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			div_q.rem <= prod[2*VALUE_WIDTH-1:VALUE_WIDTH];
			div_q.dvd <= prod[VALUE_WIDTH-1:0];
			div_q.quo <= '0;
			div_q.dsr <= c_s1;
			tag_q <= tag_s1;
		end
	end

endmodule

FILE: sv/dlm_cell.sv
// One restoring division cell: develops one quotient bit per request per cycle while en is high.
module dlm_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_i,
	input dlm_pkg::div_t div_i,
	input dlm_pkg::tag_t tag_i,
	output logic vld_q,
	output dlm_pkg::div_t div_q,
	output dlm_pkg::tag_t tag_q
);
	import dlm_pkg::*;

	logic [VALUE_WIDTH:0] trial;
	logic [VALUE_WIDTH:0] trial_sub;
	logic fits;
	div_t div_d;

	always_comb begin
		trial = {div_i.rem, div_i.dvd[VALUE_WIDTH-1]};
		trial_sub = trial - {1'b0, div_i.dsr};
		fits = trial >= {1'b0, div_i.dsr};
		div_d.rem = fits ? trial_sub[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
		div_d.dvd = {div_i.dvd[VALUE_WIDTH-2:0], 1'b0};
		div_d.quo = {div_i.quo[VALUE_WIDTH-2:0], fits};
		div_d.dsr = div_i.dsr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q <= div_d;
			tag_q <= tag_i;
		end
	end

endmodule

FILE: sv/dlm_checker.sv
// Port-level checks of the deadband linear map and their binding to the top level.
module dlm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input dlm_pkg::val_t mapped,
	input dlm_pkg::region_t region
);
	import dlm_pkg::*;

	// Input back-pressure only appears while a result is waiting at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// Once the waiting result is taken, the skid entry moves up and input reopens.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input stayed stalled after the output drained");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (region <= REGION_CLAMP_HIGH))
		else $error("result carries an undefined region code");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mapped) && $stable(region))
		else $error("stalled result changed or vanished");

endmodule

bind deadband_linear_map dlm_checker u_dlm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.mapped(results.mapped),
	.region(results.region)
);

FILE: dv/tb_top.sv
// Self-checking testbench of the deadband linear map with a predictor.
`timescale 1ns / 1ps

module tb_top;
	import dlm_pkg::*;

	typedef struct {
		logic command;
		val_t sample;
	} map_req_t;

	localparam val_t V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam val_t V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam longint OUT_MAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam longint QUOT_CAP = longint'(1) <<< 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_PAUSE = 3 * (VALUE_WIDTH + 3);
	localparam int MAX_PRINTED = 100;

	localparam cfg_t RESET_CFG = '{RST_SRC_LOWEST, RST_SRC_BAND_LOW, RST_SRC_CENTER,
		RST_SRC_BAND_HIGH, RST_SRC_HIGHEST, RST_DST_LOWEST, RST_DST_CENTER, RST_DST_HIGHEST};
	localparam cfg_t WIDE_CFG = '{V_MIN, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MAX};
	localparam cfg_t FLAT_CFG = '{V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN};
	localparam cfg_t SWAPPED_CFG = '{V_MIN, val_t'(-1), val_t'(0), val_t'(0), val_t'(1),
		V_MAX, V_MIN, V_MAX};

	int fwd_points[11] = '{-32768, -32767, -1025, -1024, -1, 0, 1, 1024, 1025, 32766, 32767};
	int inv_points[9] = '{-32768, -32767, -12345, -1, 0, 1, 12345, 32766, 32767};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_idx;
	val_t cfg_data;

	dlm_in_if samples_if();
	dlm_out_if results_if();

	deadband_linear_map DUT (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	cfg_t map_cfg;
	map_req_t pending_reqs[$];
	res_t expected_results[$];
	map_req_t next_req;
	int gap_pct;
	int stall_pct;
	bit long_hold;
	int hold_count = 0;
	int cycle_count = 0;
	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_settings;

	always #5 clk = ~clk;

	function automatic longint scaled_quotient(longint a, longint b, longint c);
		longint q;
		if (c == 0)
			return 0;
		q = (a * b) / c;
		if (q > QUOT_CAP)
			q = QUOT_CAP;
		else if (q < -QUOT_CAP)
			q = -QUOT_CAP;
		return q;
	endfunction

	function automatic res_t map_sample(logic cmd, val_t smp);
		longint x, y, sl, sbl, sc, sbh, sh, dl, dc, dh;
		region_t reg_code;
		res_t r;
		x = smp;
		sl = map_cfg.src_lowest;
		sbl = map_cfg.src_band_low;
		sc = map_cfg.src_center;
		sbh = map_cfg.src_band_high;
		sh = map_cfg.src_highest;
		dl = map_cfg.dst_lowest;
		dc = map_cfg.dst_center;
		dh = map_cfg.dst_highest;
		if (cmd == CMD_FWD) begin
			if (x <= sl) begin
				y = dl;
				reg_code = REGION_CLAMP_LOW;
			end else if (x >= sh) begin
				y = dh;
				reg_code = REGION_CLAMP_HIGH;
			end else if (x < sbl) begin
				y = scaled_quotient(x - sl, dc - dl, sbl - sl) + dl;
				reg_code = REGION_LOWER;
			end else if (x > sbh) begin
				y = scaled_quotient(x - sbh, dh - dc, sh - sbh) + dc;
				reg_code = REGION_UPPER;
			end else begin
				y = dc;
				reg_code = REGION_MID;
			end
		end else begin
			if (x <= dl) begin
				y = sl;
				reg_code = REGION_CLAMP_LOW;
			end else if (x >= dh) begin
				y = sh;
				reg_code = REGION_CLAMP_HIGH;
			end else if (x == dc) begin
				y = sc;
				reg_code = REGION_MID;
			end else if (x < dc) begin
				y = scaled_quotient(x - dl, sbl - sl, dc - dl) + sl;
				reg_code = REGION_LOWER;
			end else begin
				y = scaled_quotient(x - dc, sh - sbh, dh - dc) + sbh;
				reg_code = REGION_UPPER;
			end
		end
		if (y > OUT_MAX)
			y = OUT_MAX;
		else if (y < OUT_MIN)
			y = OUT_MIN;
		r.mapped = val_t'(y);
		r.region = reg_code;
		return r;
	endfunction

	function automatic cfg_t random_cfg(bit ordered);
		cfg_t c;
		int sl, sbl, sc, sbh, dl, dc;
		if (ordered) begin
			sl = int'($urandom_range(0, 12000)) - 32768;
			sbl = sl + int'($urandom_range(1, 12000));
			sc = sbl + int'($urandom_range(0, 4000));
			sbh = sc + int'($urandom_range(0, 4000));
			dl = int'($urandom_range(0, 20000)) - 32768;
			dc = dl + int'($urandom_range(1, 20000));
			c.src_lowest = val_t'(sl);
			c.src_band_low = val_t'(sbl);
			c.src_center = val_t'(sc);
			c.src_band_high = val_t'(sbh);
			c.src_highest = val_t'(sbh + 1 + int'($urandom_range(0, 32766 - sbh)));
			c.dst_lowest = val_t'(dl);
			c.dst_center = val_t'(dc);
			c.dst_highest = val_t'(dc + 1 + int'($urandom_range(0, 32766 - dc)));
		end else begin
			c = {$urandom, $urandom, $urandom, $urandom};
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(0, 4))
					0: c[i*VALUE_WIDTH +: VALUE_WIDTH] = V_MIN;
					1: c[i*VALUE_WIDTH +: VALUE_WIDTH] = V_MAX;
					default: ;
				endcase
			end
		end
		return c;
	endfunction

	task automatic report_mismatch(string what);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
	endtask

	task automatic load_map_cfg(cfg_t c);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= cfg_idx_t'(i);
			case (cfg_idx_t'(i))
				REG_SRC_LOWEST: cfg_data <= c.src_lowest;
				REG_SRC_BAND_LOW: cfg_data <= c.src_band_low;
				REG_SRC_CENTER: cfg_data <= c.src_center;
				REG_SRC_BAND_HIGH: cfg_data <= c.src_band_high;
				REG_SRC_HIGHEST: cfg_data <= c.src_highest;
				REG_DST_LOWEST: cfg_data <= c.dst_lowest;
				REG_DST_CENTER: cfg_data <= c.dst_center;
				REG_DST_HIGHEST: cfg_data <= c.dst_highest;
				default: cfg_data <= '0;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		map_cfg = c;
		n_settings++;
	endtask

	task automatic drain_all();
		while (pending_reqs.size() != 0 || samples_if.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic run_phase(cfg_t c, int n_items, int gap, int stall, bit hold);
		map_req_t req;
		int pick;
		int slot;
		load_map_cfg(c);
		@(negedge clk);
		gap_pct = gap;
		stall_pct = stall;
		long_hold = hold;
		for (int i = 0; i < n_items; i++) begin
			req.command = logic'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				slot = $urandom_range(0, 7);
				req.sample = c[slot*VALUE_WIDTH +: VALUE_WIDTH]
					+ val_t'(int'($urandom_range(0, 4)) - 2);
			end else if (pick < 40) begin
				req.sample = $urandom_range(0, 1) ? V_MIN : V_MAX;
			end else begin
				req.sample = val_t'($urandom);
			end
			pending_reqs.push_back(req);
		end
		drain_all();
		long_hold = 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
		end else begin
			if (samples_if.valid && samples_if.ready) begin
				expected_results.push_back(map_sample(samples_if.command, samples_if.sample));
				n_sent++;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
					next_req = pending_reqs.pop_front();
					samples_if.valid <= 1'b1;
					samples_if.command <= next_req.command;
					samples_if.sample <= next_req.sample;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (long_hold && hold_count < HOLD_CYCLES) begin
			hold_count <= hold_count + 1;
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result mapped=%0d region=%0d with no request pending",
					results_if.mapped, results_if.region));
			end else begin
				want = expected_results.pop_front();
				if (results_if.mapped !== want.mapped)
					report_mismatch($sformatf("mapped %0d, expected %0d",
						results_if.mapped, want.mapped));
				if (results_if.region !== want.region)
					report_mismatch($sformatf("region %0d, expected %0d",
						results_if.region, want.region));
			end
			n_checked++;
		end
	end

	initial begin
		map_req_t req;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		map_cfg = RESET_CFG;
		gap_pct = 0;
		stall_pct = 0;
		long_hold = 1'b0;
		n_settings = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Region boundaries of the default transfer, both directions.
		foreach (fwd_points[i]) begin
			req.command = CMD_FWD;
			req.sample = val_t'(fwd_points[i]);
			pending_reqs.push_back(req);
		end
		foreach (inv_points[i]) begin
			req.command = CMD_INV;
			req.sample = val_t'(inv_points[i]);
			pending_reqs.push_back(req);
		end
		drain_all();

		run_phase(random_cfg(1'b1), 200, 0, 0, 1'b1);
		run_phase(WIDE_CFG, 150, 77, 0, 1'b0);
		run_phase(random_cfg(1'b0), 200, 0, 77, 1'b0);
		run_phase(random_cfg(1'b1), 200, 12, 12, 1'b0);
		run_phase(FLAT_CFG, 80, 0, 0, 1'b0);
		run_phase(SWAPPED_CFG, 100, 77, 77, 1'b0);
		run_phase(RESET_CFG, 100, 12, 12, 1'b0);

		$display("Summary: %0d requests sent, %0d results checked, %0d register settings.",
			n_sent, n_checked, n_settings);
		$display("Summary: four idling phases plus a %0d-cycle output hold.", HOLD_CYCLES);
		if (n_errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/dlm_pkg.sv
sv/dlm_if.sv
sv/dlm_front.sv
sv/dlm_cell.sv
sv/deadband_linear_map.sv
sv/dlm_checker.sv
dv/tb_top.sv
